// File: design/b58enc_pkg.sv
// ----------------------------------------------------------------------------
// b58enc_pkg
// Types, command/status bundles and base-58 digit helpers for the encoder.
// ----------------------------------------------------------------------------
package b58enc_pkg;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [6:0] char_code;
      logic       last_char;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic run;
      logic ext;
      logic emit_one;
      logic emit_dig;
      logic clear;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic stored;
      logic ndig_zero;
      logic run_last;
      logic carry_zero;
      logic last_ff;
      logic lz_zero;
      logic lz_one;
      logic idx_zero;
   } status_type;

   typedef struct packed {
      logic [7:0] q;
      logic [5:0] r;
   } step_type;

   localparam logic [6:0] ONE_CHAR = 7'h31;

   // entry d holds {d*256 / 58, d*256 % 58}, built by stepping 256 = 4*58 + 24
   function automatic logic [63:0][13:0] build_div_tab();
      logic [63:0][13:0] tab;
      logic [8:0]        q;
      logic [6:0]        r;
      q = '0;
      r = '0;
      for (int d = 0; d < 64; d++) begin
         tab[d] = {q[7:0], r[5:0]};
         r = r + 7'd24;
         q = q + 9'd4;
         if (r >= 7'd58) begin
            r = r - 7'd58;
            q = q + 9'd1;
         end
      end
      return tab;
   endfunction

   localparam logic [63:0][13:0] DIV_TAB = build_div_tab();

   // (d*256 + c) split into quotient and remainder by 58; d < 58, c < 256
   function automatic step_type digit_step(input logic [5:0] d, input logic [7:0] c);
      step_type   res;
      logic [7:0] q1;
      logic [5:0] r1;
      logic [8:0] s;
      logic [2:0] q2;
      logic [8:0] sub;
      q1 = DIV_TAB[d][13:6];
      r1 = DIV_TAB[d][5:0];
      s  = {3'b000, r1} + {1'b0, c};
      if (s >= 9'd290) begin
         q2 = 3'd5; sub = 9'd290;
      end else if (s >= 9'd232) begin
         q2 = 3'd4; sub = 9'd232;
      end else if (s >= 9'd174) begin
         q2 = 3'd3; sub = 9'd174;
      end else if (s >= 9'd116) begin
         q2 = 3'd2; sub = 9'd116;
      end else if (s >= 9'd58) begin
         q2 = 3'd1; sub = 9'd58;
      end else begin
         q2 = 3'd0; sub = 9'd0;
      end
      res.q = q1 + {5'b00000, q2};
      res.r = 6'(s - sub);
      return res;
   endfunction

   // alphabet: 1-9, A-H, J-N, P-Z, a-k, m-z
   function automatic logic [6:0] b58_char(input logic [5:0] d);
      logic [6:0] ch;
      if (d < 6'd9)       ch = 7'h31 + {1'b0, d};
      else if (d < 6'd17) ch = 7'h41 + {1'b0, d - 6'd9};
      else if (d < 6'd22) ch = 7'h4A + {1'b0, d - 6'd17};
      else if (d < 6'd33) ch = 7'h50 + {1'b0, d - 6'd22};
      else if (d < 6'd44) ch = 7'h61 + {1'b0, d - 6'd33};
      else                ch = 7'h6D + {1'b0, d - 6'd44};
      return ch;
   endfunction

endpackage

// File: design/b58enc_ctrl.sv
// ----------------------------------------------------------------------------
// b58enc_ctrl
// Sequencer: per-byte digit update pass, carry extension, text output.
// ----------------------------------------------------------------------------
module b58enc_ctrl
   import b58enc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_EXT,
      ST_ONES,
      ST_DIGS
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (!status.stored)
                  state_in = status.last_ff ? ST_EXT : ST_IDLE;
               else
                  state_in = status.ndig_zero ? ST_EXT : ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.run = 1'b1;
            if (status.run_last)
               state_in = ST_EXT;
         end
         ST_EXT: begin
            cmd.ext = 1'b1;
            if (status.carry_zero) begin
               if (!status.last_ff)
                  state_in = ST_IDLE;
               else
                  state_in = status.lz_zero ? ST_DIGS : ST_ONES;
            end
         end
         ST_ONES: begin
            cmd.emit_one = 1'b1;
            if (status.lz_one) begin
               if (status.ndig_zero) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  state_in  = ST_DIGS;
               end
            end
         end
         ST_DIGS: begin
            cmd.emit_dig = 1'b1;
            if (status.idx_zero) begin
               cmd.clear = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

// File: design/b58enc_dpath.sv
// ----------------------------------------------------------------------------
// b58enc_dpath
// Digit memory, carry register, counters and the registered character output.
// ----------------------------------------------------------------------------
module b58enc_dpath
   import b58enc_pkg::*;
#(
   parameter int MAX_BYTES = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_strobe,
   output rsp_type    rsp_data
);

   localparam int DIGIT_CAP = (MAX_BYTES * 138) / 100 + 2;
   localparam int AW        = $clog2(DIGIT_CAP);
   localparam int DW        = $clog2(DIGIT_CAP + 1);
   localparam int BW        = $clog2(MAX_BYTES + 1);
   localparam logic [BW-1:0] MAX_CNT = BW'(MAX_BYTES);

   logic [5:0]    digit_mem [DIGIT_CAP];

   logic [7:0]    carry_ff, carry_in;
   logic          last_ff, last_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [DW-1:0] ndig_ff, ndig_in;
   logic [BW-1:0] bcnt_ff, bcnt_in;
   logic [BW-1:0] lz_ff, lz_in;
   logic          inlz_ff, inlz_in;
   logic [5:0]    rd_ff;
   logic          strobe_ff, strobe_in;
   rsp_type       rsp_ff, rsp_in;

   logic          stored;
   logic [DW-1:0] ndig_dec;
   logic [AW-1:0] raddr, waddr;
   logic          we;
   logic [5:0]    step_d;
   step_type      step;

   assign stored   = (bcnt_ff < MAX_CNT);
   assign ndig_dec = ndig_ff - DW'(1);
   assign step_d   = cmd.run ? rd_ff : 6'd0;
   assign step     = digit_step(step_d, carry_ff);

   assign status.stored     = stored;
   assign status.ndig_zero  = (ndig_ff == '0);
   assign status.run_last   = (DW'(idx_ff) + DW'(1) == ndig_ff);
   assign status.carry_zero = (carry_ff == 8'd0);
   assign status.last_ff    = cmd.load ? req_data.last_byte : last_ff;
   assign status.lz_zero    = (lz_ff == '0);
   assign status.lz_one     = (lz_ff == BW'(1));
   assign status.idx_zero   = (idx_ff == '0);

   // read one ahead of the digit being worked on
   always_comb begin
      if (cmd.run)
         raddr = idx_ff + AW'(1);
      else if (cmd.emit_dig)
         raddr = idx_ff - AW'(1);
      else if (cmd.ext || cmd.emit_one)
         raddr = ndig_dec[AW-1:0];
      else
         raddr = '0;
   end

   assign we    = cmd.run || (cmd.ext && carry_ff != 8'd0);
   assign waddr = cmd.run ? idx_ff : ndig_ff[AW-1:0];

   always_comb begin
      carry_in  = carry_ff;
      last_in   = last_ff;
      idx_in    = idx_ff;
      ndig_in   = ndig_ff;
      bcnt_in   = bcnt_ff;
      lz_in     = lz_ff;
      inlz_in   = inlz_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;

      if (cmd.load) begin
         carry_in = stored ? req_data.byte_value : 8'd0;
         last_in  = req_data.last_byte;
         idx_in   = '0;
         if (stored) begin
            bcnt_in = bcnt_ff + BW'(1);
            if (inlz_ff) begin
               if (req_data.byte_value == 8'd0)
                  lz_in = lz_ff + BW'(1);
               else
                  inlz_in = 1'b0;
            end
         end
      end

      if (cmd.run) begin
         carry_in = step.q;
         idx_in   = idx_ff + AW'(1);
      end

      if (cmd.ext) begin
         if (carry_ff != 8'd0) begin
            carry_in = step.q;
            ndig_in  = ndig_ff + DW'(1);
         end else begin
            idx_in   = ndig_dec[AW-1:0];
         end
      end

      if (cmd.emit_one) begin
         lz_in            = lz_ff - BW'(1);
         strobe_in        = 1'b1;
         rsp_in.char_code = ONE_CHAR;
         rsp_in.last_char = status.lz_one && status.ndig_zero;
      end

      if (cmd.emit_dig) begin
         idx_in           = idx_ff - AW'(1);
         strobe_in        = 1'b1;
         rsp_in.char_code = b58_char(rd_ff);
         rsp_in.last_char = status.idx_zero;
      end

      if (cmd.clear) begin
         bcnt_in = '0;
         lz_in   = '0;
         inlz_in = 1'b1;
         ndig_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ndig_ff   <= '0;
         bcnt_ff   <= '0;
         lz_ff     <= '0;
         inlz_ff   <= 1'b1;
         strobe_ff <= 1'b0;
      end else begin
         ndig_ff   <= ndig_in;
         bcnt_ff   <= bcnt_in;
         lz_ff     <= lz_in;
         inlz_ff   <= inlz_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      carry_ff <= carry_in;
      last_ff  <= last_in;
      idx_ff   <= idx_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (we)
         digit_mem[waddr] <= step.r;
      rd_ff <= digit_mem[raddr];
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// File: design/base58_encoder_core.sv
// ----------------------------------------------------------------------------
// base58_encoder_core
// Base58 text encoder for a big-endian byte string, one byte per transfer.
// ----------------------------------------------------------------------------
// A stored byte keeps busy high while the digit memory, ndig base-58 digits so
// far, is updated one digit per cycle.
// On the last byte, characters follow the update, one per cycle, lz + ndig in
// all, from a registered output; the receiver cannot stall.
// Bytes past MAX_BYTES are dropped; one not flagged last leaves busy low.
// Synchronous reset returns to idle; the digit memory is not cleared.
module base58_encoder_core
   import b58enc_pkg::*;
#(
   parameter int MAX_BYTES = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   b58enc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   b58enc_dpath #(
      .MAX_BYTES (MAX_BYTES)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // characters only come out of a conversion in progress
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("character transfer without a conversion in progress");

   // text is sent without gaps until the flagged last character
   a_stream_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_char |=> rsp_strobe)
      else $error("gap in character stream");

   a_last_ends_stream: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last_char |=> !rsp_strobe)
      else $error("character transfer after last character");

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives byte strings into base58_encoder_core and checks each emitted
// character against a software Base58 encoding of the same string.
// ----------------------------------------------------------------------------
module testbench
   import b58enc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_BYTES   = 32;
   localparam int CYCLE_LIMIT = 400000;
   localparam bit [0:57][7:0] B58_ALPHABET =
      "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

   // Expected text of the string in flight, built as bytes are transferred.
   class base58_text_checker;
      rsp_type    pending_chars[$];
      logic [7:0] held_bytes[$];
      int         zero_run;
      bit         in_zero_run;
      int         errors;
      int         chars_checked;

      function new();
         zero_run      = 0;
         in_zero_run   = 1'b1;
         errors        = 0;
         chars_checked = 0;
      endfunction

      function void take_byte(req_type item);
         int      digits[48];
         int      ndig;
         int      carry;
         rsp_type ch;
         // bytes past the store size are dropped, a final flag still counts
         if (held_bytes.size() < MAX_BYTES) begin
            held_bytes.push_back(item.byte_value);
            if (in_zero_run) begin
               if (item.byte_value == 8'h00)
                  zero_run++;
               else
                  in_zero_run = 1'b0;
            end
         end
         if (!item.last_byte)
            return;
         ndig = 0;
         foreach (held_bytes[i]) begin
            carry = held_bytes[i];
            for (int j = 0; j < ndig; j++) begin
               carry += digits[j] * 256;
               digits[j] = carry % 58;
               carry /= 58;
            end
            while (carry != 0) begin
               digits[ndig] = carry % 58;
               ndig++;
               carry /= 58;
            end
         end
         for (int k = 0; k < zero_run; k++) begin
            ch.char_code = B58_ALPHABET[0][6:0];
            ch.last_char = (k + 1 == zero_run + ndig);
            pending_chars.push_back(ch);
         end
         for (int j = ndig - 1; j >= 0; j--) begin
            ch.char_code = B58_ALPHABET[digits[j]][6:0];
            ch.last_char = (j == 0);
            pending_chars.push_back(ch);
         end
         held_bytes.delete();
         zero_run    = 0;
         in_zero_run = 1'b1;
      endfunction

      function void check_char(rsp_type got);
         rsp_type want;
         if (pending_chars.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: unexpected character code %h last %b",
                        got.char_code, got.last_char);
            return;
         end
         want = pending_chars.pop_front();
         chars_checked++;
         if (got.char_code !== want.char_code || got.last_char !== want.last_char) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: char %0d: expected code %h last %b, got code %h last %b",
                        chars_checked, want.char_code, want.last_char,
                        got.char_code, got.last_char);
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   base58_text_checker score;
   int idle_pct;
   int bytes_sent;
   int strings_sent;
   int long_strings;
   int cycles;

   base58_encoder_core #(.MAX_BYTES(MAX_BYTES)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   // monitor: results first, then the input transfer of the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            score.check_char(rsp_data);
         if (start && !busy)
            score.take_byte(req_data);
      end
   end

   // called and returns at a falling edge
   task automatic send_byte(input req_type item);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_string(input int len, input int zeros, input bit all_ff);
      req_type item;
      for (int k = 0; k < len; k++) begin
         if (k < zeros)
            item.byte_value = 8'h00;
         else if (all_ff)
            item.byte_value = 8'hFF;
         else
            item.byte_value = 8'($urandom_range(255));
         item.last_byte = (k == len - 1);
         send_byte(item);
      end
      strings_sent++;
      if (len > MAX_BYTES)
         long_strings++;
   endtask

   task automatic send_random_string();
      int pick;
      int len;
      int zeros;
      pick = $urandom_range(99);
      if (pick < 60)
         len = $urandom_range(1, 8);
      else if (pick < 80)
         len = $urandom_range(9, MAX_BYTES - 1);
      else if (pick < 90)
         len = MAX_BYTES;
      else
         len = $urandom_range(MAX_BYTES + 1, MAX_BYTES + 8);
      zeros = ($urandom_range(3) == 0) ? $urandom_range(1, len) : 0;
      send_string(len, zeros, $urandom_range(7) == 0);
   endtask

   initial begin
      int idle_plan[3];
      idle_plan = '{10, 87, 0};
      score        = new();
      cycles       = 0;
      bytes_sent   = 0;
      strings_sent = 0;
      long_strings = 0;
      idle_pct     = 0;
      reset        = 1'b1;
      start        = 1'b0;
      req_data     = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: single zero, max byte, leading zeros, all-zero, digit wrap
      send_byte({8'h00, 1'b1});
      send_byte({8'hFF, 1'b1});
      send_byte({8'h01, 1'b1});
      send_byte({8'h00, 1'b0});
      send_byte({8'h00, 1'b0});
      send_byte({8'h01, 1'b1});
      send_byte({8'h00, 1'b0});
      send_byte({8'h00, 1'b1});
      send_byte({8'h39, 1'b1});
      send_byte({8'h3A, 1'b1});
      send_byte({8'h80, 1'b0});
      send_byte({8'h7F, 1'b1});
      strings_sent += 8;
      // widest value: a full store of 0xFF gives the longest text
      send_string(MAX_BYTES, 0, 1'b1);

      for (int p = 0; p < 3; p++) begin
         idle_pct = idle_plan[p];
         while (bytes_sent < 350 * (p + 1) / 3)
            send_random_string();
      end
      start <= 1'b0;

      while (score.pending_chars.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("Transferred %0d bytes in %0d strings (%0d over-long), checked %0d characters",
               bytes_sent, strings_sent, long_strings, score.chars_checked);
      $display("Mismatches: %0d, characters still expected: %0d",
               score.errors, score.pending_chars.size());
      if (score.errors == 0 && score.pending_chars.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
